// ===== hw/rtl/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer package
// Shared transaction types, command codes, register indexes and bus phases.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    // Command codes carried by an input transaction.
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_READ_ACK  = 3'd3;
    localparam logic [2:0] CMD_READ_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP      = 3'd5;
    localparam logic [2:0] CMD_TO_WRITE  = 3'd6;
    localparam logic [2:0] CMD_TO_READ   = 3'd7;

    // Phase switch modes.
    localparam logic [1:0] SW_NONE       = 2'd0;
    localparam logic [1:0] SW_RESTART    = 2'd1;
    localparam logic [1:0] SW_STOP_START = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ADDR_NACK  = 2'd1;
    localparam logic [1:0] ST_DATA_NACK  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_HIGH_TICKS  = 3'd0;
    localparam logic [2:0] REG_LOW_TICKS   = 3'd1;
    localparam logic [2:0] REG_DEV_ADDR    = 3'd2;
    localparam logic [2:0] REG_WRITE_MODE  = 3'd3;
    localparam logic [2:0] REG_READ_MODE   = 3'd4;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    // Bus sequencing phases.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SPREP  = 3'd1,
        PH_SSETUP = 3'd2,
        PH_SHOLD  = 3'd3,
        PH_BLOW   = 3'd4,
        PH_BHIGH  = 3'd5,
        PH_PLOW   = 3'd6,
        PH_PHIGH  = 3'd7
    } t_phase;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       read_not_write;
        logic       sda_sample;
    } t_in_item;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] high_phase_ticks;
        logic [15:0] low_phase_ticks;
        logic [6:0]  device_address;
        logic [1:0]  write_switch_mode;
        logic [1:0]  read_switch_mode;
    } t_cfg;

endpackage

// ===== hw/rtl/i2c_master_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Tick-driven I2C controller with a configuration port and a buffered result.
// ----------------------------------------------------------------------------
// Each input transaction is one timing tick carrying the sampled SDA level and,
// while the sequencer is idle, a command; each tick yields exactly one result
// transaction with the SCL and SDA drive-low levels, ready, done, the last read
// byte and the status. One tick is taken in every clock cycle: the bus state is
// updated by a single pass of next-state logic at acceptance, and the result
// goes into a two-entry output buffer, so input keeps flowing during an output
// stall while the skid entry is free and stops only when both are full. Every
// bit lasts low_phase_ticks plus high_phase_ticks ticks (each at least one
// tick). Configuration registers are written by index through the write port;
// the user must write them only while idle, as the block does not enforce it.
module i2c_master_byte_sequencer #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  i2cmbs_pkg::t_in_item                      i_in_item,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output i2cmbs_pkg::t_out_item                     o_out_item,
    input  logic                                      i_cfg_we,
    input  logic [i2cmbs_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [i2cmbs_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata
);
    import i2cmbs_pkg::*;

    t_cfg      r_cfg;
    t_out_item result;
    t_out_item r_out;
    t_out_item r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      in_fire;
    logic      out_fire;

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_phase_ticks  <= 16'd5;
            r_cfg.low_phase_ticks   <= 16'd2;
            r_cfg.device_address    <= 7'd0;
            r_cfg.write_switch_mode <= SW_NONE;
            r_cfg.read_switch_mode  <= SW_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HIGH_TICKS: r_cfg.high_phase_ticks  <= i_cfg_wdata;
                REG_LOW_TICKS:  r_cfg.low_phase_ticks   <= i_cfg_wdata;
                REG_DEV_ADDR:   r_cfg.device_address    <= i_cfg_wdata[6:0];
                REG_WRITE_MODE: r_cfg.write_switch_mode <= i_cfg_wdata[1:0];
                REG_READ_MODE:  r_cfg.read_switch_mode  <= i_cfg_wdata[1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    i2cmbs_core #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Output buffer: main register plus one skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Payload of the output buffer.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

// ===== hw/rtl/i2cmbs_core.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer core
// Bus state registers and the single-pass next-state logic for one tick.
// ----------------------------------------------------------------------------
module i2cmbs_core #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cmbs_pkg::t_in_item  i_item,
    input  i2cmbs_pkg::t_cfg      i_cfg,
    output i2cmbs_pkg::t_out_item o_result
);
    import i2cmbs_pkg::*;

    localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
    localparam logic [CW-1:0] LIM = CW'((64'd1 << TICK_COUNT_BITS) - 64'd1);

    t_phase                     r_phase, n_phase;
    logic [TICK_COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [3:0]                 r_bit, n_bit;
    logic [7:0]                 r_shift, n_shift;
    logic [2:0]                 r_active, n_active;
    logic [1:0]                 r_status, n_status;
    logic                       r_scl, n_scl;
    logic                       r_sda, n_sda;
    logic [7:0]                 r_rx, n_rx;

    logic                       done;
    logic                       go;
    logic                       fin;
    logic                       held;
    t_phase                     tgt;
    logic [1:0]                 mode;
    logic [CW-1:0]              raw_len;
    logic [CW-1:0]              clamp_len;
    logic [TICK_COUNT_BITS-1:0] len;
    logic [TICK_COUNT_BITS-1:0] cnt_inc;
    t_phase                     start_tgt;

    // Length of the current phase, clamped to the counter range and at least one tick.
    always_comb begin
        if (r_phase == PH_SSETUP || r_phase == PH_SHOLD ||
            r_phase == PH_BHIGH  || r_phase == PH_PHIGH) begin
            raw_len = CW'(i_cfg.high_phase_ticks);
        end else begin
            raw_len = CW'(i_cfg.low_phase_ticks);
        end
        clamp_len = (raw_len > LIM) ? LIM : raw_len;
        if (clamp_len == '0) begin
            clamp_len = CW'(1);
        end
        len     = clamp_len[TICK_COUNT_BITS-1:0];
        cnt_inc = r_cnt + TICK_COUNT_BITS'(1);
    end

    // A start from a held bus first spends one low phase with SDA released.
    assign start_tgt = r_scl ? PH_SPREP : PH_SSETUP;

    // Next state for one tick.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_active = r_active;
        n_status = r_status;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_rx     = r_rx;
        done     = 1'b0;
        go       = 1'b0;
        fin      = 1'b0;
        held     = 1'b0;
        tgt      = PH_IDLE;
        mode     = SW_NONE;

        if (i_fire) begin
            if (r_phase == PH_IDLE) begin
                // Idle: take the command of this transaction.
                if (i_item.command != CMD_NONE) begin
                    n_active = i_item.command;
                    n_status = ST_OK;
                    n_bit    = 4'd0;
                    case (i_item.command)
                        CMD_START: begin
                            n_shift = {i_cfg.device_address, i_item.read_not_write};
                            go      = 1'b1;
                            tgt     = start_tgt;
                        end
                        CMD_WRITE: begin
                            n_shift = i_item.tx_byte;
                            go      = 1'b1;
                            tgt     = PH_BLOW;
                        end
                        CMD_READ_ACK, CMD_READ_NACK: begin
                            n_shift = 8'd0;
                            go      = 1'b1;
                            tgt     = PH_BLOW;
                        end
                        CMD_STOP: begin
                            go  = 1'b1;
                            tgt = PH_PLOW;
                        end
                        default: begin
                            mode = (i_item.command == CMD_TO_WRITE) ?
                                   i_cfg.write_switch_mode : i_cfg.read_switch_mode;
                            n_shift = {i_cfg.device_address,
                                       (i_item.command == CMD_TO_READ)};
                            if (mode == SW_RESTART) begin
                                go  = 1'b1;
                                tgt = start_tgt;
                            end else if (mode == SW_STOP_START) begin
                                go  = 1'b1;
                                tgt = PH_PLOW;
                            end else begin
                                done = 1'b1;
                            end
                        end
                    endcase
                end
            end else begin
                // Busy: count ticks and move on at the end of the phase.
                n_cnt = cnt_inc;
                if (cnt_inc >= len) begin
                    case (r_phase)
                        PH_SPREP: begin
                            go  = 1'b1;
                            tgt = PH_SSETUP;
                        end
                        PH_SSETUP: begin
                            go  = 1'b1;
                            tgt = PH_SHOLD;
                        end
                        PH_SHOLD: begin
                            n_bit = 4'd0;
                            go    = 1'b1;
                            tgt   = PH_BLOW;
                        end
                        PH_BLOW: begin
                            go  = 1'b1;
                            tgt = PH_BHIGH;
                        end
                        PH_BHIGH: begin
                            if (r_bit < 4'd8) begin
                                n_shift = {r_shift[6:0], i_item.sda_sample};
                                n_bit   = r_bit + 4'd1;
                                go      = 1'b1;
                                tgt     = PH_BLOW;
                            end else if (r_active == CMD_READ_ACK ||
                                         r_active == CMD_READ_NACK) begin
                                n_rx = r_shift;
                                fin  = 1'b1;
                                held = 1'b1;
                            end else if (i_item.sda_sample) begin
                                n_status = (r_active == CMD_WRITE) ? ST_DATA_NACK
                                                                   : ST_ADDR_NACK;
                                go  = 1'b1;
                                tgt = PH_PLOW;
                            end else begin
                                fin  = 1'b1;
                                held = 1'b1;
                            end
                        end
                        PH_PLOW: begin
                            go  = 1'b1;
                            tgt = PH_PHIGH;
                        end
                        PH_PHIGH: begin
                            // Stop then start: the start follows the free-bus phase.
                            if ((r_active == CMD_TO_WRITE || r_active == CMD_TO_READ) &&
                                r_status == ST_OK) begin
                                go  = 1'b1;
                                tgt = PH_SSETUP;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // Line levels on entry to a new phase.
            if (go) begin
                n_phase = tgt;
                n_cnt   = '0;
                case (tgt)
                    PH_SPREP: begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                    end
                    PH_SSETUP: begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end
                    PH_SHOLD: begin
                        n_scl = 1'b0;
                        n_sda = 1'b1;
                    end
                    PH_BLOW: begin
                        n_scl = 1'b1;
                        if (n_bit < 4'd8) begin
                            n_sda = (n_active == CMD_READ_ACK || n_active == CMD_READ_NACK) ?
                                    1'b0 : ~n_shift[7];
                        end else begin
                            n_sda = (n_active == CMD_READ_ACK);
                        end
                    end
                    PH_BHIGH: begin
                        n_scl = 1'b0;
                    end
                    PH_PLOW: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                    end
                    PH_PHIGH: begin
                        n_scl = 1'b0;
                        n_sda = 1'b1;
                    end
                    default: begin
                        n_scl = r_scl;
                    end
                endcase
            end

            // Command complete: back to idle with SDA released.
            if (fin) begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
                n_scl   = held;
                n_sda   = 1'b0;
                done    = 1'b1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_bit    <= 4'd0;
            r_shift  <= 8'd0;
            r_active <= CMD_NONE;
            r_status <= ST_OK;
            r_scl    <= 1'b0;
            r_sda    <= 1'b0;
            r_rx     <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_active <= n_active;
            r_status <= n_status;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_rx     <= n_rx;
        end
    end

    // Result of this tick, taken from the next state.
    always_comb begin
        o_result.scl_drive_low = n_scl;
        o_result.sda_drive_low = n_sda;
        o_result.ready_res     = (n_phase == PH_IDLE);
        o_result.done_res      = done;
        o_result.read_byte     = n_rx;
        o_result.status        = n_status;
    end

endmodule

// ===== hw/rtl/i2cmbs_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer checker
// Port-level assertions on the handshakes and result contents, bound to the top.
// ----------------------------------------------------------------------------
module i2cmbs_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input i2cmbs_pkg::t_out_item o_out_item
);
    import i2cmbs_pkg::*;

    // Input back-pressure only ever comes from results waiting to be taken.
    a_ready_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // Every accepted tick leaves a result on the output.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted tick produced no result");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // A finished command leaves the sequencer idle with SDA released.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |->
        (o_out_item.ready_res && !o_out_item.sda_drive_low))
        else $error("command finished without returning to idle");

endmodule

bind i2c_master_byte_sequencer i2cmbs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte sequencer testbench
// Drives timing ticks through the valid/ready input channel, predicts the
// SCL/SDA drive levels, ready, done, read byte and status of every tick, and
// checks each output transaction in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;

    import i2cmbs_pkg::*;

    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          MAX_REPORTS   = 10;
    // The switch mode field is two bits wide; its unused code behaves as none.
    localparam logic [1:0]  SW_UNUSED     = 2'd3;

    // Clock, reset and the block's ports.
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    t_in_item                   in_item   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    t_out_item                  out_item;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;

    // Idling percentages for each side of the block.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Run statistics.
    int unsigned cycle_count    = 0;
    int unsigned ticks_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned commands_taken = 0;
    int unsigned done_pulses    = 0;
    int unsigned nack_stops     = 0;

    // Expected line states, oldest first.
    t_out_item expected_line_states[$];

    // Shadow of the sequencer: configuration and bus state.
    t_cfg         cfg_shadow  = '{16'd5, 16'd2, 7'd0, SW_NONE, SW_NONE};
    t_phase       bus_phase   = PH_IDLE;
    int unsigned  phase_count = 0;
    logic [3:0]   bits_done   = '0;
    logic [7:0]   shift_reg   = '0;
    logic [2:0]   op_cmd      = CMD_NONE;
    logic [1:0]   op_status   = ST_OK;
    logic         scl_low     = 1'b0;
    logic         sda_low     = 1'b0;
    logic [7:0]   last_rx     = '0;
    logic         cmd_done    = 1'b0;

    i2c_master_byte_sequencer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abandon the run if it hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, expected_line_states.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------------

    // Length of a phase in ticks; a zero setting still lasts one tick.
    function automatic int unsigned phase_limit(input t_phase p);
        int unsigned n;
        if (p inside {PH_SSETUP, PH_SHOLD, PH_BHIGH, PH_PHIGH})
            n = cfg_shadow.high_phase_ticks;
        else
            n = cfg_shadow.low_phase_ticks;
        return (n == 0) ? 1 : n;
    endfunction

    function automatic logic op_is_read();
        return (op_cmd == CMD_READ_ACK) || (op_cmd == CMD_READ_NACK);
    endfunction

    // Enter a phase and set the line levels it drives.
    function automatic void enter_phase(input t_phase p);
        bus_phase   = p;
        phase_count = 0;
        case (p)
            PH_SPREP: begin
                scl_low = 1'b1;
                sda_low = 1'b0;
            end
            PH_SSETUP: begin
                scl_low = 1'b0;
                sda_low = 1'b0;
            end
            PH_SHOLD: begin
                scl_low = 1'b0;
                sda_low = 1'b1;
            end
            PH_BLOW: begin
                scl_low = 1'b1;
                // Data bits go out MSB first; on reads the ninth bit is the host's ACK.
                if (bits_done < 4'd8)
                    sda_low = op_is_read() ? 1'b0 : ~shift_reg[7];
                else
                    sda_low = (op_cmd == CMD_READ_ACK);
            end
            PH_BHIGH: scl_low = 1'b0;
            PH_PLOW: begin
                scl_low = 1'b1;
                sda_low = 1'b1;
            end
            PH_PHIGH: begin
                scl_low = 1'b0;
                sda_low = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void finish_command(input logic held);
        bus_phase   = PH_IDLE;
        phase_count = 0;
        scl_low     = held;
        sda_low     = 1'b0;
        cmd_done    = 1'b1;
    endfunction

    // A command offered while idle starts its bus sequence.
    function automatic void take_command(input t_in_item item);
        logic [1:0] mode;
        if (item.command == CMD_NONE)
            return;
        commands_taken++;
        op_cmd    = item.command;
        op_status = ST_OK;
        bits_done = '0;
        case (item.command)
            CMD_START: begin
                shift_reg = {cfg_shadow.device_address, item.read_not_write};
                enter_phase(scl_low ? PH_SPREP : PH_SSETUP);
            end
            CMD_WRITE: begin
                shift_reg = item.tx_byte;
                enter_phase(PH_BLOW);
            end
            CMD_READ_ACK, CMD_READ_NACK: begin
                shift_reg = '0;
                enter_phase(PH_BLOW);
            end
            CMD_STOP: enter_phase(PH_PLOW);
            default: begin
                mode = (item.command == CMD_TO_WRITE) ? cfg_shadow.write_switch_mode
                                                      : cfg_shadow.read_switch_mode;
                shift_reg = {cfg_shadow.device_address, item.command == CMD_TO_READ};
                if (mode == SW_RESTART)
                    enter_phase(scl_low ? PH_SPREP : PH_SSETUP);
                else if (mode == SW_STOP_START)
                    enter_phase(PH_PLOW);
                else
                    cmd_done = 1'b1;
            end
        endcase
    endfunction

    // Move on from a phase whose ticks have run out.
    function automatic void step_phase(input logic sda);
        case (bus_phase)
            PH_SPREP:  enter_phase(PH_SSETUP);
            PH_SSETUP: enter_phase(PH_SHOLD);
            PH_SHOLD: begin
                bits_done = '0;
                enter_phase(PH_BLOW);
            end
            PH_BLOW:   enter_phase(PH_BHIGH);
            PH_BHIGH: begin
                if (bits_done < 4'd8) begin
                    shift_reg = {shift_reg[6:0], sda};
                    bits_done++;
                    enter_phase(PH_BLOW);
                end else if (op_is_read()) begin
                    last_rx = shift_reg;
                    finish_command(1'b1);
                end else if (sda) begin
                    // Not acknowledged: report it and stop the bus.
                    op_status = (op_cmd == CMD_WRITE) ? ST_DATA_NACK : ST_ADDR_NACK;
                    nack_stops++;
                    enter_phase(PH_PLOW);
                end else begin
                    finish_command(1'b1);
                end
            end
            PH_PLOW:   enter_phase(PH_PHIGH);
            PH_PHIGH: begin
                // A stop-then-start switch carries on into the start condition.
                if ((op_cmd == CMD_TO_WRITE || op_cmd == CMD_TO_READ) && op_status == ST_OK) begin
                    sda_low = 1'b0;
                    enter_phase(PH_SSETUP);
                end else begin
                    finish_command(1'b0);
                end
            end
            default:   finish_command(1'b0);
        endcase
    endfunction

    // Advance the shadow by one tick and return the line state it yields.
    function automatic t_out_item predict_tick(input t_in_item item);
        t_out_item r;
        cmd_done = 1'b0;
        if (bus_phase == PH_IDLE) begin
            take_command(item);
        end else begin
            phase_count++;
            if (phase_count >= phase_limit(bus_phase))
                step_phase(item.sda_sample);
        end
        if (cmd_done)
            done_pulses++;
        r.scl_drive_low = scl_low;
        r.sda_drive_low = sda_low;
        r.ready_res     = (bus_phase == PH_IDLE);
        r.done_res      = cmd_done;
        r.read_byte     = last_rx;
        r.status        = op_status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stalls and in-order checking
    // ------------------------------------------------------------------------

    function automatic void check_line_state(input t_out_item got);
        t_out_item want;
        if (expected_line_states.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR: unexpected output transaction %h", got);
            return;
        end
        want = expected_line_states.pop_front();
        results_seen++;
        if (got.scl_drive_low !== want.scl_drive_low ||
            got.sda_drive_low !== want.sda_drive_low ||
            got.ready_res     !== want.ready_res     ||
            got.done_res      !== want.done_res      ||
            got.read_byte     !== want.read_byte     ||
            got.status        !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("ERROR: result %0d expected scl %b sda %b rdy %b done %b rx %h st %0d",
                         results_seen, want.scl_drive_low, want.sda_drive_low,
                         want.ready_res, want.done_res, want.read_byte, want.status);
                $display("       got                scl %b sda %b rdy %b done %b rx %h st %0d",
                         got.scl_drive_low, got.sda_drive_low, got.ready_res,
                         got.done_res, got.read_byte, got.status);
            end
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_line_state(out_item);
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one tick and predict its result once the transaction is taken.
    task automatic send_tick(input t_in_item item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_line_states.push_back(predict_tick(item));
        ticks_sent++;
    endtask

    // Issue a command from idle and tick until it has finished. The nack bit
    // is the SDA level seen in the acknowledge slot; other samples are random,
    // and stray commands are offered while the sequencer is busy.
    task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx,
                               input logic rnw, input logic nack);
        t_in_item item;
        item.command        = cmd;
        item.tx_byte        = tx;
        item.read_not_write = rnw;
        item.sda_sample     = 1'($urandom_range(0, 1));
        send_tick(item);
        while (bus_phase != PH_IDLE) begin
            item.command = ($urandom_range(0, 7) == 0) ?
                           3'($urandom_range(CMD_START, CMD_TO_READ)) : CMD_NONE;
            item.tx_byte        = 8'($urandom);
            item.read_not_write = 1'($urandom);
            if (bus_phase == PH_BHIGH && bits_done == 4'd8)
                item.sda_sample = nack;
            else
                item.sda_sample = 1'($urandom_range(0, 1));
            send_tick(item);
        end
    endtask

    // Hold off the input until every expected result has come out.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_line_states.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers while the block is idle.
    task automatic load_settings(input t_cfg c);
        logic [CFG_INDEX_BITS-1:0] reg_index [5];
        logic [CFG_DATA_BITS-1:0]  reg_value [5];
        reg_index = '{REG_HIGH_TICKS, REG_LOW_TICKS, REG_DEV_ADDR,
                      REG_WRITE_MODE, REG_READ_MODE};
        reg_value = '{c.high_phase_ticks, c.low_phase_ticks,
                      16'(c.device_address), 16'(c.write_switch_mode),
                      16'(c.read_switch_mode)};
        wait_results_drained();
        for (int r = 0; r < 5; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_index[r];
            cfg_wdata <= reg_value[r];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        cfg_shadow = c;
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.high_phase_ticks  = 16'($urandom_range(1, 3));
        c.low_phase_ticks   = 16'($urandom_range(0, 3));
        c.device_address    = 7'($urandom);
        c.write_switch_mode = 2'($urandom_range(SW_NONE, SW_UNUSED));
        c.read_switch_mode  = 2'($urandom_range(SW_NONE, SW_UNUSED));
        return c;
    endfunction

    // One bus conversation: mostly start, a few transfers or switches, stop.
    task automatic random_sequence();
        logic [2:0] op;
        if ($urandom_range(0, 9) < 2) begin
            run_command(3'($urandom_range(CMD_NONE, CMD_TO_READ)), 8'($urandom),
                        1'($urandom), 1'($urandom_range(0, 1)));
            return;
        end
        run_command(CMD_START, 8'($urandom), 1'($urandom), $urandom_range(0, 9) == 0);
        if (op_status == ST_OK) begin
            repeat ($urandom_range(1, 4)) begin
                op = 3'($urandom_range(CMD_WRITE, CMD_TO_READ));
                if (op == CMD_STOP)
                    op = CMD_READ_NACK;
                run_command(op, 8'($urandom), 1'($urandom), $urandom_range(0, 7) == 0);
                if (op_status != ST_OK)
                    break;
            end
        end
        // After a NACK the block has stopped already; sometimes stop again.
        if (op_status == ST_OK || $urandom_range(0, 1) == 1)
            run_command(CMD_STOP, 8'($urandom), 1'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset timing, transfers and stops with no start, and immediate switches.
    task automatic test_free_bus();
        load_settings('{16'd5, 16'd2, 7'd0, SW_NONE, SW_NONE});
        run_command(CMD_NONE, 8'h00, 1'b0, 1'b0);
        run_command(CMD_WRITE, 8'hA5, 1'b0, 1'b0);
        run_command(CMD_READ_ACK, 8'h00, 1'b1, 1'b0);
        run_command(CMD_STOP, 8'hFF, 1'b0, 1'b0);
        run_command(CMD_TO_WRITE, 8'h00, 1'b0, 1'b0);
        run_command(CMD_TO_READ, 8'h00, 1'b0, 1'b0);
    endtask

    // Full write then read conversation with both switch styles.
    task automatic test_transfers();
        load_settings('{16'd2, 16'd0, 7'd127, SW_RESTART, SW_STOP_START});
        run_command(CMD_START, 8'h00, 1'b0, 1'b0);
        run_command(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
        run_command(CMD_WRITE, 8'h00, 1'b0, 1'b0);
        // SCL is held low here, so the repeated start begins with a low phase.
        run_command(CMD_TO_WRITE, 8'h00, 1'b0, 1'b0);
        run_command(CMD_TO_READ, 8'h00, 1'b0, 1'b0);
        run_command(CMD_READ_ACK, 8'h00, 1'b0, 1'b0);
        run_command(CMD_READ_NACK, 8'h00, 1'b0, 1'b0);
        run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    // Address and data not acknowledged, and the unused switch code.
    task automatic test_nacks();
        load_settings('{16'd1, 16'd1, 7'h55, SW_UNUSED, SW_RESTART});
        run_command(CMD_START, 8'h00, 1'b1, 1'b1);
        run_command(CMD_START, 8'h00, 1'b0, 1'b0);
        run_command(CMD_WRITE, 8'h3C, 1'b0, 1'b1);
        run_command(CMD_START, 8'h00, 1'b0, 1'b0);
        run_command(CMD_TO_WRITE, 8'h00, 1'b0, 1'b0);
        run_command(CMD_TO_READ, 8'h00, 1'b0, 1'b1);
        run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    // Long phases, then the shortest ones.
    task automatic test_extreme_timing();
        load_settings('{16'd120, 16'd80, 7'd127, SW_STOP_START, SW_STOP_START});
        run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
        load_settings('{16'd1, 16'd0, 7'd0, SW_NONE, SW_RESTART});
        run_command(CMD_START, 8'h00, 1'b1, 1'b0);
        run_command(CMD_READ_NACK, 8'h00, 1'b0, 1'b0);
        run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    // Random conversations under short random timing, reconfigured now and then.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned first_tick;
        int unsigned last_load;
        first_tick = ticks_sent;
        load_settings(random_settings());
        last_load = ticks_sent;
        while (ticks_sent - first_tick < n_items) begin
            if (ticks_sent - last_load > 160) begin
                load_settings(random_settings());
                last_load = ticks_sent;
            end
            random_sequence();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 82;
        test_free_bus();
        test_transfers();
        test_nacks();
        test_random_traffic(180);

        send_idle_pct = 82;
        recv_idle_pct = 32;
        test_random_traffic(180);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_extreme_timing();
        test_random_traffic(180);

        wait_results_drained();
        $display("Sent %0d ticks carrying %0d commands: %0d completions, %0d NACK stops.",
                 ticks_sent, commands_taken, done_pulses, nack_stops);
        $display("Checked %0d results over reset, extreme and random timings; %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && expected_line_states.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
